@@ src/lmfe_pkg.sv @@
package lmfe_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int MAX_RESULTS    = 4;
    localparam int RES_IDX_W      = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_W         = 20;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd50000;
    localparam logic [7:0]        SYNC_BYTE     = 8'h55;
    localparam logic [5:0]        ENHANCED_LIM  = 6'h3C;
    localparam logic [7:0]        CSUM_GOOD     = 8'hFF;

    localparam logic [2:0] CMD_START_SEND = 3'd0;
    localparam logic [2:0] CMD_START_POLL = 3'd1;
    localparam logic [2:0] CMD_TX_BYTE    = 3'd2;
    localparam logic [2:0] CMD_RX_BYTE    = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;

    localparam logic [2:0] KIND_BREAK   = 3'd0;
    localparam logic [2:0] KIND_TX      = 3'd1;
    localparam logic [2:0] KIND_RX      = 3'd2;
    localparam logic [2:0] KIND_OK      = 3'd3;
    localparam logic [2:0] KIND_CSERR   = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT = 3'd5;
    localparam logic [2:0] KIND_REJECT  = 3'd6;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEND = 2'd1,
        MODE_POLL = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] frame_id;
        logic [3:0] data_len;
        logic [7:0] byte_val;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_out;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } result_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]          count;
        result_t [MAX_RESULTS-1:0]     res;
    } job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_status_t;

    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    function automatic logic [7:0] csum_add(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

@@ src/lmfe_front.sv @@
module lmfe_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lmfe_pkg::in_item_t          in_item,
    input  logic                        cfg_wr_en,
    input  logic [lmfe_pkg::TICK_W-1:0] cfg_wr_data,
    input  lmfe_pkg::queue_status_t     q_status,
    output logic                        push,
    output lmfe_pkg::job_t              push_job
);
    import lmfe_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [7:0]        acc_reg, acc_next;
    logic [3:0]        count_reg, count_next;
    logic [3:0]        len_reg, len_next;
    logic [TICK_W-1:0] wait_reg, wait_next;
    logic [TICK_W-1:0] limit_reg;

    logic       accept;
    logic [7:0] pid;
    logic [7:0] csum;
    logic [3:0] count_inc;
    logic       len_ok;
    logic       timed_out;
    job_t       job;

    assign in_ready  = !q_status.full;
    assign accept    = in_valid && in_ready;
    assign pid       = protect_id(in_item.frame_id);
    assign csum      = csum_add(acc_reg, in_item.byte_val);
    assign count_inc = count_reg + 4'd1;
    assign len_ok    = in_item.data_len <= 4'(MAX_DATA_BYTES);
    assign timed_out = wait_reg >= limit_reg;

    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            unique case (in_item.cmd)
                CMD_START_SEND:
                begin
                    if (mode_reg == MODE_IDLE && len_ok)
                        mode_next = (in_item.data_len == 4'd0) ? MODE_IDLE : MODE_SEND;
                end
                CMD_START_POLL:
                begin
                    if (mode_reg == MODE_IDLE && len_ok)
                        mode_next = MODE_POLL;
                end
                CMD_TX_BYTE:
                begin
                    if (mode_reg == MODE_SEND && count_inc >= len_reg)
                        mode_next = MODE_IDLE;
                end
                CMD_RX_BYTE:
                begin
                    if (mode_reg == MODE_POLL && count_reg >= len_reg)
                        mode_next = MODE_IDLE;
                end
                CMD_TICK:
                begin
                    if (mode_reg == MODE_POLL && timed_out)
                        mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        len_next   = len_reg;
        wait_next  = wait_reg;
        job        = '0;
        if (accept)
        begin
            unique case (in_item.cmd)
                CMD_START_SEND, CMD_START_POLL:
                begin
                    if (mode_reg != MODE_IDLE || !len_ok)
                    begin
                        job.count      = RES_CNT_W'(1);
                        job.res[0]     = '{kind: KIND_REJECT, data: 8'd0};
                    end
                    else
                    begin
                        acc_next   = (in_item.frame_id < ENHANCED_LIM) ? pid : 8'd0;
                        count_next = 4'd0;
                        len_next   = in_item.data_len;
                        wait_next  = '0;
                        job.res[0] = '{kind: KIND_BREAK, data: 8'd0};
                        job.res[1] = '{kind: KIND_TX, data: SYNC_BYTE};
                        job.res[2] = '{kind: KIND_TX, data: pid};
                        job.count  = RES_CNT_W'(3);
                        if (in_item.cmd == CMD_START_SEND && in_item.data_len == 4'd0)
                        begin
                            job.res[3] = '{kind: KIND_TX, data: ~acc_next};
                            job.count  = RES_CNT_W'(4);
                        end
                    end
                end
                CMD_TX_BYTE:
                begin
                    job.count = RES_CNT_W'(1);
                    if (mode_reg != MODE_SEND)
                    begin
                        job.res[0] = '{kind: KIND_REJECT, data: 8'd0};
                    end
                    else
                    begin
                        acc_next   = csum;
                        count_next = count_inc;
                        job.res[0] = '{kind: KIND_TX, data: in_item.byte_val};
                        if (count_inc >= len_reg)
                        begin
                            job.res[1] = '{kind: KIND_TX, data: ~csum};
                            job.count  = RES_CNT_W'(2);
                        end
                    end
                end
                CMD_RX_BYTE:
                begin
                    job.count = RES_CNT_W'(1);
                    if (mode_reg != MODE_POLL)
                    begin
                        job.res[0] = '{kind: KIND_REJECT, data: 8'd0};
                    end
                    else
                    begin
                        acc_next = csum;
                        if (count_reg < len_reg)
                        begin
                            count_next = count_inc;
                            job.res[0] = '{kind: KIND_RX, data: in_item.byte_val};
                        end
                        else
                        begin
                            job.res[0].kind = (csum == CSUM_GOOD) ? KIND_OK : KIND_CSERR;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (mode_reg == MODE_POLL)
                    begin
                        if (timed_out)
                        begin
                            job.count  = RES_CNT_W'(1);
                            job.res[0] = '{kind: KIND_TIMEOUT, data: 8'd0};
                        end
                        else
                        begin
                            wait_next = wait_reg + TICK_W'(1);
                        end
                    end
                end
                default:
                begin
                    job.count  = RES_CNT_W'(1);
                    job.res[0] = '{kind: KIND_REJECT, data: 8'd0};
                end
            endcase
        end
    end

    assign push     = accept && (job.count != '0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            count_reg <= '0;
            len_reg   <= '0;
            wait_reg  <= '0;
            limit_reg <= TIMEOUT_RESET;
        end
        else
        begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            wait_reg  <= wait_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");
    a_send_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_SEND |-> count_reg < len_reg)
        else $error("send frame past its length");
    a_idle_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE && mode_next != MODE_IDLE) |-> push_job.count == RES_CNT_W'(3))
        else $error("frame start without header results");
`endif

endmodule

@@ src/lmfe_queue.sv @@
module lmfe_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lmfe_pkg::job_t          push_job,
    input  logic                    pop,
    output lmfe_pkg::job_t          pop_job,
    output lmfe_pkg::queue_status_t status
);
    import lmfe_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign status.full     = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign status.nonempty = cnt_reg != '0;
    assign pop_job         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.nonempty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with split pointers");
`endif

endmodule

@@ src/lmfe_back.sv @@
module lmfe_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lmfe_pkg::queue_status_t q_status,
    input  lmfe_pkg::job_t          pop_job,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lmfe_pkg::out_item_t     out_item
);
    import lmfe_pkg::*;

    job_t                 cur_reg, cur_next;
    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    logic                 busy_reg, busy_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic    load_out;
    logic    emit;
    logic    finish;
    result_t cur_res;

    assign load_out = !out_valid_reg || out_ready;
    assign emit     = load_out && busy_reg;
    assign finish   = emit && (idx_reg == RES_IDX_W'(cur_reg.count - RES_CNT_W'(1)));
    assign pop      = q_status.nonempty && (!busy_reg || finish);
    assign cur_res  = cur_reg.res[idx_reg];

    always_comb
    begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_next.kind     = cur_res.kind;
            out_next.byte_out = cur_res.data;
            out_next.last     = finish;
            idx_next          = idx_reg + RES_IDX_W'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
            busy_next = 1'b0;
        if (pop)
        begin
            busy_next = 1'b1;
            cur_next  = pop_job;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (RES_CNT_W'(idx_reg) < cur_reg.count))
        else $error("result index past job");
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!busy_reg || finish))
        else $error("job popped while busy");
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted result not shown");
`endif

endmodule

@@ src/lin_master_frame_engine.sv @@
// Channel   Signals                               Accepted when
// input     in_valid, in_ready, in_item           in_valid && in_ready
// output    out_valid, out_ready, out_item        out_valid && out_ready
// config    cfg_wr_en, cfg_wr_data                cfg_wr_en
//
// An item is classified and the frame state updated in the cycle it is accepted;
// items with no result (ticks that do not time out) flow at one per cycle while the queue is not full.
// With an empty queue, a job passes the queue and the current-job register to out_valid.
// Each item's results (up to four) leave the output register at one per cycle unless out_ready holds them.
// A four-entry job queue lets input run ahead; in_ready drops only when it is full.
// Reset clears frame state, queue and output valid; the timeout limit resets to 50000.
module lin_master_frame_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lmfe_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lmfe_pkg::out_item_t         out_item,
    input  logic                        cfg_wr_en,
    input  logic [lmfe_pkg::TICK_W-1:0] cfg_wr_data
);
    import lmfe_pkg::*;

    queue_status_t q_status;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          pop_job;

    lmfe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    lmfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    lmfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_job   (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
